// File: src/msa_pkg.sv
// Shared constants, codes and result types for the track run-length decoder.
package msa_pkg;

  localparam int SECTOR_BYTES = 512;
  localparam int MAX_SPT      = 32;
  localparam int MAX_TRACKS   = 256;
  localparam int HEADER_LEN   = 10;
  localparam int TRACK_LIMIT  = 16384;
  localparam int IMAGE_LIMIT  = 8388608;

  localparam logic [15:0] MAGIC_WORD = 16'd3599;
  localparam logic [7:0]  ESC_BYTE   = 8'hE5;

  localparam int SPT_W   = $clog2(MAX_SPT + 1);
  localparam int TB_W    = $clog2(TRACK_LIMIT + 1);
  localparam int TN_W    = $clog2(MAX_TRACKS + 1);
  localparam int TRK_W   = TN_W + 1;
  localparam int PROD_W  = TRK_W + TB_W;
  localparam int IMG_W   = 24;
  localparam int HC_W    = $clog2(HEADER_LEN);

  localparam int MAX_RES   = 3;
  localparam int RB_DEPTH  = 4;
  localparam int RB_PTR_W  = $clog2(RB_DEPTH);
  localparam int RB_CNT_W  = $clog2(RB_DEPTH + 1);

  // header byte positions that complete a big-endian word
  localparam logic [HC_W-1:0] HB_MAGIC = HC_W'(1);
  localparam logic [HC_W-1:0] HB_SPT   = HC_W'(3);
  localparam logic [HC_W-1:0] HB_SIDES = HC_W'(5);
  localparam logic [HC_W-1:0] HB_FIRST = HC_W'(7);

  localparam logic [2:0] ERR_OK         = 3'd0;
  localparam logic [2:0] ERR_MAGIC      = 3'd1;
  localparam logic [2:0] ERR_SHORT_HDR  = 3'd2;
  localparam logic [2:0] ERR_NO_LEN     = 3'd3;
  localparam logic [2:0] ERR_SHORT_RAW  = 3'd4;
  localparam logic [2:0] ERR_SHORT_PACK = 3'd5;
  localparam logic [2:0] ERR_GEOMETRY   = 3'd6;

  typedef struct packed {
    logic [7:0]       value;
    logic [TB_W-1:0]  count;
    logic             eot;
    logic             eoi;
    logic [2:0]       err;
    logic [IMG_W-1:0] image;
    logic             last;
  } res_t;

  typedef struct packed {
    logic [MAX_RES-1:0]       valid;
    res_t [MAX_RES-1:0]       slot;
  } res_bundle_t;

endpackage

// File: src/msa_core.sv
// Parser state and per-byte decode step producing up to three result slots.
module msa_core import msa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        acc_i,
  input  logic [7:0]  byte_i,
  input  logic        last_i,
  output res_bundle_t bundle_o
);

  typedef enum logic [2:0] {PH_HEAD, PH_LEN, PH_RAW, PH_PACK, PH_SKIP, PH_DONE} phase_e;
  typedef enum logic [1:0] {ESC_IDLE, ESC_FILL, ESC_HI, ESC_LO} esc_e;

  phase_e           phase_q, phase_d;
  esc_e             esc_q, esc_d;
  logic [HC_W-1:0]  hc_q, hc_d;
  logic [SPT_W-1:0] spt_q, spt_d;
  logic             side2_q, side2_d;
  logic [15:0]      first_q, first_d;
  logic [TRK_W-1:0] total_q, total_d;
  logic [TRK_W-1:0] trk_q, trk_d;
  logic [15:0]      left_q, left_d;
  logic [TB_W-1:0]  wr_q, wr_d;
  logic [7:0]       fill_q, fill_d;
  logic [7:0]       hi_q, hi_d;
  logic             err_q, err_d;
  logic [IMG_W-1:0] img_q, img_d;

  logic [TB_W-1:0]   ts;
  logic [15:0]       word;
  logic [16:0]       tracks;
  logic [TRK_W-1:0]  tn;
  logic [PROD_W-1:0] prod;
  logic [15:0]       left_dec;
  logic [TB_W-1:0]   room;
  logic [TB_W-1:0]   cnt_c;
  logic [TB_W-1:0]   wr_inc;
  logic [TRK_W-1:0]  trk_inc;
  logic              close, pad, eoi;
  logic              va, vb, vc;
  res_t              ra, rb, rc;
  logic [2:0]        last_vec;

  assign ts       = TB_W'(spt_q * SECTOR_BYTES);
  assign word     = {hi_q, byte_i};
  assign tracks   = {1'b0, word} - {1'b0, first_q} + 17'd1;
  assign tn       = side2_q ? {tracks[TN_W-1:0], 1'b0} : {1'b0, tracks[TN_W-1:0]};
  assign prod     = PROD_W'(tn) * PROD_W'(ts);
  assign left_dec = left_q - 16'd1;
  assign room     = ts - wr_q;
  assign cnt_c    = (word > 16'(room)) ? room : TB_W'(word);
  assign wr_inc   = wr_q + TB_W'(1);
  assign trk_inc  = trk_q + TRK_W'(1);

  always_comb begin
    phase_d = phase_q;
    esc_d   = esc_q;
    hc_d    = hc_q;
    spt_d   = spt_q;
    side2_d = side2_q;
    first_d = first_q;
    total_d = total_q;
    trk_d   = trk_q;
    left_d  = left_q;
    wr_d    = wr_q;
    fill_d  = fill_q;
    hi_d    = hi_q;
    err_d   = err_q;
    img_d   = img_q;
    close   = 1'b0;
    pad     = 1'b0;
    eoi     = 1'b0;
    va      = 1'b0;
    vb      = 1'b0;
    vc      = 1'b0;
    ra      = '0;
    rb      = '0;
    rc      = '0;
    ra.image = img_q;
    rb.image = img_q;
    rc.image = img_q;

    if (acc_i && !err_q) begin
      unique case (phase_q)
        PH_HEAD: begin
          hc_d = hc_q + HC_W'(1);
          if (!hc_q[0]) begin
            hi_d = byte_i;
          end else begin
            unique case (hc_q)
              HB_MAGIC: begin
                if (word != MAGIC_WORD) begin
                  va     = 1'b1;
                  ra.err = ERR_MAGIC;
                  err_d  = 1'b1;
                end
              end
              HB_SPT: begin
                if (word == 16'd0 || word > 16'(MAX_SPT) ||
                    32'(word) * SECTOR_BYTES > TRACK_LIMIT) begin
                  va     = 1'b1;
                  ra.err = ERR_GEOMETRY;
                  err_d  = 1'b1;
                end else begin
                  spt_d = word[SPT_W-1:0];
                end
              end
              HB_SIDES: begin
                if (word > 16'd1) begin
                  va     = 1'b1;
                  ra.err = ERR_GEOMETRY;
                  err_d  = 1'b1;
                end else begin
                  side2_d = word[0];
                end
              end
              HB_FIRST: begin
                first_d = word;
              end
              default: begin
                // last track word closes the header
                if (word < first_q || tracks > 17'(MAX_TRACKS) ||
                    prod > PROD_W'(IMAGE_LIMIT)) begin
                  va     = 1'b1;
                  ra.err = ERR_GEOMETRY;
                  err_d  = 1'b1;
                end else begin
                  total_d = tn;
                  img_d   = prod[IMG_W-1:0];
                  trk_d   = '0;
                  hc_d    = '0;
                  phase_d = PH_LEN;
                end
              end
            endcase
          end
        end
        PH_LEN: begin
          if (hc_q == '0) begin
            hi_d = byte_i;
            hc_d = HC_W'(1);
          end else begin
            hc_d  = '0;
            wr_d  = '0;
            esc_d = ESC_IDLE;
            if (word == 16'(ts)) begin
              phase_d = PH_RAW;
            end else if (word == 16'd0) begin
              left_d   = '0;
              phase_d  = PH_PACK;
              va       = 1'b1;
              ra.count = ts;
              wr_d     = ts;
              close    = 1'b1;
            end else begin
              left_d  = word;
              phase_d = PH_PACK;
            end
          end
        end
        PH_RAW: begin
          va       = 1'b1;
          ra.value = byte_i;
          ra.count = TB_W'(1);
          wr_d     = wr_inc;
          close    = (wr_inc >= ts);
        end
        PH_PACK: begin
          left_d = left_dec;
          unique case (esc_q)
            ESC_IDLE: begin
              if (byte_i == ESC_BYTE && left_dec >= 16'd3) begin
                esc_d = ESC_FILL;
              end else begin
                va       = 1'b1;
                ra.value = byte_i;
                ra.count = TB_W'(1);
                wr_d     = wr_inc;
              end
            end
            ESC_FILL: begin
              fill_d = byte_i;
              esc_d  = ESC_HI;
            end
            ESC_HI: begin
              hi_d  = byte_i;
              esc_d = ESC_LO;
            end
            ESC_LO: begin
              esc_d = ESC_IDLE;
              if (cnt_c != '0) begin
                va       = 1'b1;
                ra.value = fill_q;
                ra.count = cnt_c;
                wr_d     = wr_q + cnt_c;
              end
            end
          endcase
          if (va && wr_d >= ts) begin
            close = 1'b1;
          end else if (esc_d == ESC_IDLE && left_dec == '0) begin
            // data ran out: zero padding to the track end
            vb       = 1'b1;
            rb.count = ts - wr_d;
            wr_d     = ts;
            close    = 1'b1;
            pad      = 1'b1;
          end
        end
        PH_SKIP: begin
          left_d = left_dec;
          if (left_dec == '0) begin
            phase_d = (trk_q >= total_q) ? PH_DONE : PH_LEN;
          end
        end
        PH_DONE: begin
        end
        default: begin
        end
      endcase

      if (close) begin
        trk_d = trk_inc;
        eoi   = (trk_inc >= total_q);
        if (pad) begin
          rb.eot = 1'b1;
          rb.eoi = eoi;
        end else begin
          ra.eot = 1'b1;
          ra.eoi = eoi;
        end
        if (phase_q == PH_PACK && left_d != '0) begin
          phase_d = PH_SKIP;
        end else begin
          phase_d = eoi ? PH_DONE : PH_LEN;
        end
      end
    end

    if (acc_i && last_i) begin
      if (!err_d && phase_d != PH_DONE) begin
        vc       = 1'b1;
        rc.image = img_d;
        priority if (phase_d == PH_HEAD) begin
          rc.err = ERR_SHORT_HDR;
        end else if (phase_d == PH_LEN) begin
          rc.err = ERR_NO_LEN;
        end else if (phase_d == PH_RAW) begin
          rc.err = ERR_SHORT_RAW;
        end else begin
          rc.err = ERR_SHORT_PACK;
        end
      end
      phase_d = PH_HEAD;
      esc_d   = ESC_IDLE;
      hc_d    = '0;
      spt_d   = '0;
      side2_d = 1'b0;
      first_d = '0;
      total_d = '0;
      trk_d   = '0;
      left_d  = '0;
      wr_d    = '0;
      fill_d  = '0;
      hi_d    = '0;
      err_d   = 1'b0;
      img_d   = '0;
    end

    if (vc) begin
      rc.last = 1'b1;
    end else if (vb) begin
      rb.last = 1'b1;
    end else if (va) begin
      ra.last = 1'b1;
    end
  end

  assign last_vec       = {vc & rc.last, vb & rb.last, va & ra.last};
  assign bundle_o.valid = {vc, vb, va};
  assign bundle_o.slot  = {rc, rb, ra};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEAD;
      esc_q   <= ESC_IDLE;
      hc_q    <= '0;
      spt_q   <= '0;
      side2_q <= 1'b0;
      first_q <= '0;
      total_q <= '0;
      trk_q   <= '0;
      left_q  <= '0;
      wr_q    <= '0;
      fill_q  <= '0;
      hi_q    <= '0;
      err_q   <= 1'b0;
      img_q   <= '0;
    end else begin
      phase_q <= phase_d;
      esc_q   <= esc_d;
      hc_q    <= hc_d;
      spt_q   <= spt_d;
      side2_q <= side2_d;
      first_q <= first_d;
      total_q <= total_d;
      trk_q   <= trk_d;
      left_q  <= left_d;
      wr_q    <= wr_d;
      fill_q  <= fill_d;
      hi_q    <= hi_d;
      err_q   <= err_d;
      img_q   <= img_d;
    end
  end

  a_rearm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_i && last_i |=> phase_q == PH_HEAD && !err_q)
    else $error("decoder did not re-arm after final byte");

  a_one_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (va || vb || vc) |-> $onehot(last_vec))
    else $error("item results need exactly one last marker");

  a_written: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_RAW || phase_q == PH_PACK) |-> wr_q < ts)
    else $error("track fill count reached track size without closing");

  a_eoi_eot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !((ra.eoi && !ra.eot) || (rb.eoi && !rb.eot)))
    else $error("end of image without end of track");

endmodule

// File: src/msa_rbuf.sv
// 4-entry result queue: per cycle up to three in, one out unless stalled.
module msa_rbuf import msa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  res_bundle_t bundle_i,
  output logic        stall_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output res_t        res_o
);

  res_t                mem_q [RB_DEPTH];
  logic [RB_PTR_W-1:0] wp_q, rp_q;
  logic [RB_CNT_W-1:0] cnt_q;
  logic [RB_CNT_W-1:0] npush;
  logic                pop;
  res_t                comp [MAX_RES];

  assign npush = RB_CNT_W'($countones(bundle_i.valid));
  assign pop   = out_valid_o && !out_stall_i;

  // pack valid slots to the front, keeping order
  always_comb begin
    comp[0] = bundle_i.valid[0] ? bundle_i.slot[0] :
              (bundle_i.valid[1] ? bundle_i.slot[1] : bundle_i.slot[2]);
    comp[1] = (bundle_i.valid[0] && bundle_i.valid[1]) ? bundle_i.slot[1] :
              bundle_i.slot[2];
    comp[2] = bundle_i.slot[2];
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MAX_RES; k++) begin
      if (RB_CNT_W'(k) < npush) begin
        mem_q[wp_q + RB_PTR_W'(k)] <= comp[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_q + RB_PTR_W'(npush);
      rp_q  <= rp_q + RB_PTR_W'(pop);
      cnt_q <= cnt_q + npush - RB_CNT_W'(pop);
    end
  end

  assign out_valid_o = (cnt_q != '0);
  assign res_o       = mem_q[rp_q];
  assign stall_o     = (cnt_q > RB_CNT_W'(RB_DEPTH - MAX_RES));

  a_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= RB_CNT_W'(RB_DEPTH))
    else $error("result queue overflow");

  a_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (npush != '0) |-> cnt_q <= RB_CNT_W'(RB_DEPTH - MAX_RES))
    else $error("results pushed without room for a full item");

  a_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (wp_q == rp_q))
    else $error("queue pointers disagree with fill count");

endmodule

// File: src/msa_track_rle_decoder.sv
// Top level of the archived floppy track run-length decoder.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid_i, in_stall_o, in_byte_i,        | consumer
//          | in_last_i                                 |
//  out     | out_valid_o, out_stall_i, run_value_o,    | producer
//          | run_count_o, end_of_track_o,              |
//          | end_of_image_o, error_code_o,             |
//          | image_bytes_o, last_of_item_o             |
//
// One input byte per cycle while in_stall_o is low; each byte is decoded
// in the cycle it is taken and yields 0 to 3 runs, registered in the result
// queue. Runs leave the 4-entry queue one per cycle while out_stall_i is low;
// in_stall_o rises while the queue holds more than one run, so a byte making
// 3 runs stalls input until one run is left, longer while out is stalled.
// rst_ni is asynchronous, active low, and arms the block for a new header.
module msa_track_rle_decoder import msa_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [7:0]       in_byte_i,
  input  logic             in_last_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [7:0]       run_value_o,
  output logic [TB_W-1:0]  run_count_o,
  output logic             end_of_track_o,
  output logic             end_of_image_o,
  output logic [2:0]       error_code_o,
  output logic [IMG_W-1:0] image_bytes_o,
  output logic             last_of_item_o
);

  logic        acc;
  res_bundle_t bundle;
  res_t        res;

  assign acc = in_valid_i && !in_stall_o;

  msa_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .acc_i    (acc),
    .byte_i   (in_byte_i),
    .last_i   (in_last_i),
    .bundle_o (bundle)
  );

  msa_rbuf u_rbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .bundle_i    (bundle),
    .stall_o     (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res)
  );

  assign run_value_o    = res.value;
  assign run_count_o    = res.count;
  assign end_of_track_o = res.eot;
  assign end_of_image_o = res.eoi;
  assign error_code_o   = res.err;
  assign image_bytes_o  = res.image;
  assign last_of_item_o = res.last;

endmodule

// File: bench/msa_track_rle_decoder_tb.sv
// Self-checking testbench for the archived floppy track run-length decoder.
module msa_track_rle_decoder_tb;
  import msa_pkg::*;

  localparam int QUIET_LIMIT = 5000;
  localparam int TAIL_CYCLES = 20;
  localparam int RAND_BYTES  = 160;

  typedef enum logic [2:0] {
    PH_HEADER, PH_TRKLEN, PH_RAWCOPY, PH_UNPACK, PH_DRAIN, PH_FINISHED
  } dec_phase_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } arch_item_t;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_stall_o;
  logic [7:0]       in_byte_i   = 8'h00;
  logic             in_last_i   = 1'b0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [7:0]       run_value_o;
  logic [TB_W-1:0]  run_count_o;
  logic             end_of_track_o;
  logic             end_of_image_o;
  logic [2:0]       error_code_o;
  logic [IMG_W-1:0] image_bytes_o;
  logic             last_of_item_o;

  msa_track_rle_decoder u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_byte_i      (in_byte_i),
    .in_last_i      (in_last_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .run_value_o    (run_value_o),
    .run_count_o    (run_count_o),
    .end_of_track_o (end_of_track_o),
    .end_of_image_o (end_of_image_o),
    .error_code_o   (error_code_o),
    .image_bytes_o  (image_bytes_o),
    .last_of_item_o (last_of_item_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // decoder state as seen by the predictor
  dec_phase_e  st_phase;
  logic [3:0]  st_hdr_idx;
  logic [5:0]  st_spt;
  logic [1:0]  st_sides;
  logic [15:0] st_first;
  logic [9:0]  st_tracks;
  logic [9:0]  st_track_no;
  logic [15:0] st_data_left;
  logic [14:0] st_written;
  logic [1:0]  st_esc;
  logic [7:0]  st_fill;
  logic [7:0]  st_hi;
  logic        st_err;

  res_t        step_buf [0:MAX_RES];
  int          step_n;
  res_t        want_runs [$];

  arch_item_t  arch_bytes [$];
  logic [7:0]  file_buf [$];
  int          raw_total;
  int          total_bytes;
  int          bytes_taken = 0;
  int          fail_cnt    = 0;
  int          quiet_cycles = 0;

  function automatic void clear_decoder();
    st_phase     = PH_HEADER;
    st_hdr_idx   = '0;
    st_spt       = '0;
    st_sides     = '0;
    st_first     = '0;
    st_tracks    = '0;
    st_track_no  = '0;
    st_data_left = '0;
    st_written   = '0;
    st_esc       = '0;
    st_fill      = '0;
    st_hi        = '0;
    st_err       = 1'b0;
  endfunction

  function automatic int unsigned trk_size();
    return st_spt * SECTOR_BYTES;
  endfunction

  function automatic void emit_run(input logic [7:0] v, input int unsigned c,
                                   input logic [2:0] e);
    res_t r;
    r.value = v;
    r.count = c[TB_W-1:0];
    r.eot   = 1'b0;
    r.eoi   = 1'b0;
    r.err   = e;
    r.image = IMG_W'(st_tracks * trk_size());
    r.last  = 1'b0;
    step_buf[step_n] = r;
    step_n++;
  endfunction

  function automatic void decode_fail(input logic [2:0] code);
    st_err = 1'b1;
    emit_run(8'h00, 0, code);
  endfunction

  // flags the latest run as closing its track and picks the next phase
  function automatic void close_track();
    step_buf[step_n-1].eot = 1'b1;
    st_track_no++;
    if (st_track_no >= st_tracks) step_buf[step_n-1].eoi = 1'b1;
    if (st_phase == PH_UNPACK && st_data_left != 0) st_phase = PH_DRAIN;
    else st_phase = (st_track_no >= st_tracks) ? PH_FINISHED : PH_TRKLEN;
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input logic last);
    logic [15:0] word;
    logic [3:0]  idx;
    logic [2:0]  code;
    int unsigned ntrk, ts, cnt, room;
    bit          ran;
    step_n = 0;
    ran    = 1'b0;
    ts     = trk_size();
    if (!st_err) begin
      case (st_phase)
        PH_HEADER: begin
          idx  = st_hdr_idx;
          word = {st_hi, b};
          st_hdr_idx++;
          if (!idx[0]) begin
            st_hi = b;
          end else if (idx == HB_MAGIC) begin
            if (word != MAGIC_WORD) decode_fail(ERR_MAGIC);
          end else if (idx == HB_SPT) begin
            if (word < 1 || word > MAX_SPT || word * SECTOR_BYTES > TRACK_LIMIT)
              decode_fail(ERR_GEOMETRY);
            else
              st_spt = word[5:0];
          end else if (idx == HB_SIDES) begin
            if (word > 1) decode_fail(ERR_GEOMETRY);
            else st_sides = word[1:0] + 2'd1;
          end else if (idx == HB_FIRST) begin
            st_first = word;
          end else if (word < st_first) begin
            decode_fail(ERR_GEOMETRY);
          end else begin
            ntrk = {16'd0, word} - {16'd0, st_first} + 1;
            if (ntrk > MAX_TRACKS || ntrk * st_sides * trk_size() > IMAGE_LIMIT) begin
              decode_fail(ERR_GEOMETRY);
            end else begin
              st_tracks   = 10'(ntrk * st_sides);
              st_track_no = '0;
              st_hdr_idx  = '0;
              st_phase    = PH_TRKLEN;
            end
          end
        end
        PH_TRKLEN: begin
          if (st_hdr_idx == 0) begin
            st_hi      = b;
            st_hdr_idx = 4'd1;
          end else begin
            cnt        = {16'd0, st_hi, b};
            st_hdr_idx = '0;
            st_written = '0;
            st_esc     = '0;
            if (cnt == ts) begin
              st_phase = PH_RAWCOPY;
            end else if (cnt == 0) begin
              st_data_left = '0;
              st_phase     = PH_UNPACK;
              emit_run(8'h00, ts, ERR_OK);
              st_written = ts[14:0];
              close_track();
            end else begin
              st_data_left = cnt[15:0];
              st_phase     = PH_UNPACK;
            end
          end
        end
        PH_RAWCOPY: begin
          emit_run(b, 1, ERR_OK);
          st_written++;
          if (st_written >= ts) close_track();
        end
        PH_UNPACK: begin
          st_data_left--;
          case (st_esc)
            2'd0: begin
              if (b == ESC_BYTE && st_data_left >= 3) begin
                st_esc = 2'd1;
              end else begin
                emit_run(b, 1, ERR_OK);
                st_written++;
                ran = 1'b1;
              end
            end
            2'd1: begin
              st_fill = b;
              st_esc  = 2'd2;
            end
            2'd2: begin
              st_hi  = b;
              st_esc = 2'd3;
            end
            default: begin
              cnt  = {16'd0, st_hi, b};
              room = ts - st_written;
              if (cnt > room) cnt = room;
              st_esc = 2'd0;
              if (cnt != 0) begin
                emit_run(st_fill, cnt, ERR_OK);
                st_written = 15'(st_written + cnt);
                ran = 1'b1;
              end
            end
          endcase
          if (ran && st_written >= ts) begin
            close_track();
          end else if (st_esc == 0 && st_data_left == 0) begin
            emit_run(8'h00, ts - st_written, ERR_OK);
            st_written = ts[14:0];
            close_track();
          end
        end
        PH_DRAIN: begin
          st_data_left--;
          if (st_data_left == 0)
            st_phase = (st_track_no >= st_tracks) ? PH_FINISHED : PH_TRKLEN;
        end
        default: ;
      endcase
    end
    if (last) begin
      if (!st_err && st_phase != PH_FINISHED) begin
        case (st_phase)
          PH_HEADER:  code = ERR_SHORT_HDR;
          PH_TRKLEN:  code = ERR_NO_LEN;
          PH_RAWCOPY: code = ERR_SHORT_RAW;
          default:    code = ERR_SHORT_PACK;
        endcase
        emit_run(8'h00, 0, code);
      end
      clear_decoder();
    end
    if (step_n > 0) step_buf[step_n-1].last = 1'b1;
    for (int i = 0; i < step_n; i++) want_runs.push_back(step_buf[i]);
  endfunction

  // ---- stimulus construction ----
  task automatic put_byte(input logic [7:0] b);
    file_buf.push_back(b);
  endtask

  task automatic put_word(input logic [15:0] w);
    file_buf.push_back(w[15:8]);
    file_buf.push_back(w[7:0]);
  endtask

  task automatic put_header(input logic [15:0] magic, input logic [15:0] spt,
                            input logic [15:0] sides, input logic [15:0] first,
                            input logic [15:0] last_trk);
    put_word(magic);
    put_word(spt);
    put_word(sides);
    put_word(first);
    put_word(last_trk);
  endtask

  // moves the file into the byte stream, cut to keep bytes when keep is nonzero
  task automatic close_file(input int keep);
    arch_item_t it;
    logic [7:0] junk;
    int         n;
    if (keep != 0)
      while (file_buf.size() > keep) junk = file_buf.pop_back();
    n = file_buf.size();
    for (int i = 0; i < n; i++) begin
      it.data = file_buf[i];
      it.last = (i == n - 1);
      arch_bytes.push_back(it);
    end
    file_buf.delete();
  endtask

  task automatic gen_image(input bit want_raw);
    int unsigned sel, spt, sides, first, last_trk, span, ntrk, ts, len, k, n;
    logic [15:0] w;
    sel = $urandom_range(0, 99);
    if (!want_raw && sel < 8) begin
      n = $urandom_range(1, 12);
      for (int i = 0; i < n; i++) put_byte(8'($urandom()));
      close_file(0);
    end else if (!want_raw && sel < 22) begin
      spt      = $urandom_range(1, MAX_SPT);
      sides    = $urandom_range(0, 1);
      first    = $urandom_range(0, 65535 - 4);
      last_trk = first + $urandom_range(0, 3);
      w        = MAGIC_WORD;
      case ($urandom_range(0, 5))
        0: begin
          w = 16'($urandom());
          if (w == MAGIC_WORD) w = w ^ 16'h0001;
        end
        1: spt = 0;
        2: spt = $urandom_range(MAX_SPT + 1, 65535);
        3: sides = $urandom_range(2, 65535);
        4: begin
          first    = $urandom_range(1, 65535);
          last_trk = $urandom_range(0, first - 1);
        end
        default: begin
          first    = $urandom_range(0, 65535 - MAX_TRACKS);
          last_trk = first + $urandom_range(MAX_TRACKS, 65535 - first);
        end
      endcase
      put_header(w, 16'(spt), 16'(sides), 16'(first), 16'(last_trk));
      n = $urandom_range(0, 4);
      for (int i = 0; i < n; i++) put_byte(8'($urandom()));
      close_file(0);
    end else if (!want_raw && sel < 27) begin
      // largest legal geometry, only a few empty tracks before the cut
      first = $urandom_range(0, 65535 - (MAX_TRACKS - 1));
      put_header(MAGIC_WORD, 16'(MAX_SPT), 16'd1, 16'(first),
                 16'(first + MAX_TRACKS - 1));
      n = $urandom_range(0, 3);
      for (int i = 0; i < n; i++) put_word(16'd0);
      close_file(0);
    end else begin
      spt = want_raw ? 1 :
            ($urandom_range(0, 9) == 0) ? $urandom_range(1, MAX_SPT) : $urandom_range(1, 2);
      sides = $urandom_range(0, 1);
      span  = want_raw ? 0 : $urandom_range(0, 2);
      first = $urandom_range(0, 65535 - span);
      put_header(MAGIC_WORD, 16'(spt), 16'(sides), 16'(first), 16'(first + span));
      ts   = spt * SECTOR_BYTES;
      ntrk = (span + 1) * (sides + 1);
      for (int t = 0; t < ntrk; t++) begin
        sel = $urandom_range(0, 99);
        if ((want_raw && t == 0) || (spt == 1 && sel < 5)) begin
          put_word(16'(ts));
          for (int i = 0; i < ts; i++) put_byte(8'($urandom()));
          raw_total += ts;
        end else if (sel < 25) begin
          put_word(16'd0);
        end else begin
          len = $urandom_range(1, 24);
          put_word(16'(len));
          k = len;
          while (k > 0) begin
            sel = $urandom_range(0, 99);
            if (k >= 4 && sel < 35) begin
              put_byte(ESC_BYTE);
              put_byte(8'($urandom()));
              case ($urandom_range(0, 9))
                0:       put_word(16'd0);
                1, 2:    put_word(16'hFFFF);
                3:       put_word(16'($urandom()));
                default: put_word(16'($urandom_range(1, 40)));
              endcase
              k -= 4;
            end else if (sel < 45) begin
              put_byte(ESC_BYTE);
              k--;
            end else begin
              put_byte(8'($urandom()));
              k--;
            end
          end
        end
      end
      if ($urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) put_byte(8'($urandom()));
      end
      close_file(($urandom_range(0, 3) == 0) ? $urandom_range(1, file_buf.size()) : 0);
    end
  endtask

  // ---- driver ----
  int unsigned feed_gap = 0;
  int unsigned feed_sel;
  bit          in_calm  = 1'b0;
  bit          feed_take;
  arch_item_t  feed_item;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      feed_take = in_valid_i && !in_stall_o;
      if (feed_take) begin
        decode_byte(in_byte_i, in_last_i);
        bytes_taken++;
      end
      if (!in_valid_i || feed_take) begin
        if (feed_gap > 0) begin
          feed_gap--;
          in_valid_i <= 1'b0;
        end else if (arch_bytes.size() != 0) begin
          feed_item = arch_bytes.pop_front();
          in_valid_i <= 1'b1;
          in_byte_i  <= feed_item.data;
          in_last_i  <= feed_item.last;
          feed_sel = $urandom_range(0, 99);
          if (in_calm || feed_sel < 60) feed_gap = 0;
          else if (feed_sel < 92) feed_gap = $urandom_range(1, 3);
          else feed_gap = $urandom_range(10, 40);
          if ($urandom_range(0, 29) == 0) in_calm = !in_calm;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---- monitor ----
  res_t        mon_got, mon_want;
  int unsigned stall_hold = 0;
  int unsigned mon_sel;
  bit          out_calm   = 1'b0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        mon_got.value = run_value_o;
        mon_got.count = run_count_o;
        mon_got.eot   = end_of_track_o;
        mon_got.eoi   = end_of_image_o;
        mon_got.err   = error_code_o;
        mon_got.image = image_bytes_o;
        mon_got.last  = last_of_item_o;
        if (want_runs.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("unexpected run: %h/%0d eot %b eoi %b err %0d img %0d last %b",
                     mon_got.value, mon_got.count, mon_got.eot, mon_got.eoi,
                     mon_got.err, mon_got.image, mon_got.last);
        end else begin
          mon_want = want_runs.pop_front();
          if (mon_got.value !== mon_want.value || mon_got.count !== mon_want.count ||
              mon_got.eot !== mon_want.eot || mon_got.eoi !== mon_want.eoi ||
              mon_got.err !== mon_want.err || mon_got.image !== mon_want.image ||
              mon_got.last !== mon_want.last) begin
            fail_cnt++;
            if (fail_cnt <= 10) begin
              $display("run mismatch: want %h/%0d eot %b eoi %b err %0d img %0d last %b",
                       mon_want.value, mon_want.count, mon_want.eot, mon_want.eoi,
                       mon_want.err, mon_want.image, mon_want.last);
              $display("              got  %h/%0d eot %b eoi %b err %0d img %0d last %b",
                       mon_got.value, mon_got.count, mon_got.eot, mon_got.eoi,
                       mon_got.err, mon_got.image, mon_got.last);
            end
          end
        end
      end
      if (stall_hold > 0) begin
        stall_hold--;
      end else begin
        mon_sel = $urandom_range(0, 99);
        if (out_calm || mon_sel < 60) begin
          out_stall_i <= 1'b0;
          stall_hold = out_calm ? $urandom_range(5, 40) : $urandom_range(0, 3);
        end else if (mon_sel < 92) begin
          out_stall_i <= 1'b1;
          stall_hold = $urandom_range(0, 2);
        end else begin
          out_stall_i <= 1'b1;
          stall_hold = $urandom_range(8, 30);
        end
        if ($urandom_range(0, 19) == 0) out_calm = !out_calm;
      end
    end
  end

  // ---- watchdog ----
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("simulation failed");
    $finish;
  end

  // ---- sequence ----
  initial begin
    int base;
    clear_decoder();
    raw_total = 0;

    // bad magic, then an ignored byte up to the end of file
    put_word(16'hFFFF);
    put_byte(8'h00);
    close_file(0);
    // file that ends inside the header
    put_byte(MAGIC_WORD[15:8]);
    close_file(0);
    // packed track: zero count escape, literals, short escape, zero pad, trailing byte
    put_header(MAGIC_WORD, 16'd1, 16'd0, 16'hFFFF, 16'hFFFF);
    put_word(16'd7);
    put_byte(ESC_BYTE);
    put_byte(8'hAB);
    put_word(16'd0);
    put_byte(8'h41);
    put_byte(ESC_BYTE);
    put_byte(8'h7E);
    put_byte(8'hA5);
    close_file(0);

    base = arch_bytes.size();
    gen_image(1'b1);
    while (int'(arch_bytes.size()) - raw_total < base + RAND_BYTES) gen_image(1'b0);
    total_bytes = arch_bytes.size();

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (bytes_taken < total_bytes) @(posedge clk_i);
    while (want_runs.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (fail_cnt == 0 && want_runs.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
